FILE: rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; imported by every module of the block.
package pli_pkg;

   localparam int MAX_POINTS_DEF  = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int IDX_WIDTH      = 6;
   localparam int MODE_WIDTH     = 2;
   localparam int COUNT_WIDTH    = 7;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH = 7;

   // item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // register indexes
   localparam logic CSR_EXTRAP_MODE = 1'b0;
   localparam logic CSR_POINTS      = 1'b1;

   // extrapolation modes
   localparam logic [MODE_WIDTH-1:0] EXTRAP_HOLD_END = 2'd0;
   localparam logic [MODE_WIDTH-1:0] EXTRAP_LINE_END = 2'd1;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_NO_EXTRAP  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_ZERO_WIDTH = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_SATURATED  = 2'd3;

   // quotient magnitude above 2^40 saturates outright
   localparam int                         SAT_LIMIT_WIDTH = 41;
   localparam logic [SAT_LIMIT_WIDTH-1:0] SAT_LIMIT       = 41'h100_0000_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_READ_LO,
      S_READ_HI,
      S_GRAB,
      S_MUL,
      S_DIV,
      S_SUM,
      S_READ_END,
      S_TAKE_END,
      S_FINISH
   } state_type;

endpackage

FILE: rtl/pli_mem.sv
// Knot storage: x and y tables, one write port and one registered read port.
// Depends on pli_pkg.
module pli_mem
   import pli_pkg::*;
#(
   parameter int DEPTH = MAX_POINTS_DEF,
   parameter int AW    = $clog2(MAX_POINTS_DEF),
   parameter int VW    = VALUE_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [VW-1:0] wr_x,
   input  logic [VW-1:0] wr_y,
   input  logic [AW-1:0] rd_addr,
   output logic [VW-1:0] rd_x,
   output logic [VW-1:0] rd_y
);

   logic [VW-1:0] x_mem [DEPTH];
   logic [VW-1:0] y_mem [DEPTH];
   logic [VW-1:0] rd_x_ff;
   logic [VW-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

FILE: rtl/pli_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pli_pkg.
module pli_div
   import pli_pkg::*;
#(
   parameter int NW = 2 * (VALUE_WIDTH_DEF + 1),
   parameter int DW = VALUE_WIDTH_DEF + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]   dvd_ff, dvd_in;
   logic [DW-1:0]   dvs_ff, dvs_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW:0]     rem_sh;
   logic [DW:0]     rem_sub;
   logic            ge;

   assign rem_sh  = {rem_ff, dvd_ff[NW-1]};
   assign ge      = (rem_sh >= {1'b0, dvs_ff});
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CTW'(NW);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CTW'(1);
            dvd_in = {dvd_ff[NW-2:0], ge};
            rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = dvd_ff;

endmodule

FILE: rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator. A knot write is taken while the block is idle. A query
// scans the knots (1..points_in_use of them are read), then fetches the segment, runs the
// bit-serial divider, sums and finishes; the result goes to the output register and the
// block returns to idle. End values and refused or zero width queries skip the divider.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (synchronous, active high): idle, mode 0, 2 knots in use; tables are not cleared.
module piecewise_linear_interpolator_top
   import pli_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [IDX_WIDTH-1:0]            req_knot_index,
   input  logic signed [VALUE_WIDTH-1:0]   req_x_value,
   input  logic signed [VALUE_WIDTH-1:0]   req_y_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]   rsp_result_value,
   output logic [STATUS_WIDTH-1:0]         rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]       csr_wdata
);

   localparam int VW   = VALUE_WIDTH;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int MW   = VW + 1;
   localparam int PW   = 2 * MW;
   localparam int SUMW = ((VW > SAT_LIMIT_WIDTH) ? VW : SAT_LIMIT_WIDTH) + 2;
   localparam int CMPW = (PW > SAT_LIMIT_WIDTH) ? PW : SAT_LIMIT_WIDTH;

   localparam logic signed [SUMW-1:0] SUM_MAX = (SUMW'(1) << (VW - 1)) - SUMW'(1);
   localparam logic signed [SUMW-1:0] SUM_MIN = -SUM_MAX - SUMW'(1);
   localparam logic signed [VW-1:0]   VAL_MAX = {1'b0, {(VW - 1){1'b1}}};
   localparam logic signed [VW-1:0]   VAL_MIN = {1'b1, {(VW - 1){1'b0}}};

   state_type state_ff, state_in;

   logic [MODE_WIDTH-1:0]  mode_ff;
   logic [COUNT_WIDTH-1:0] points_ff;

   logic signed [VW-1:0] xq_ff, xq_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 x0eq_ff, x0eq_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        hi_ff, hi_in;
   logic                 anc_hi_ff, anc_hi_in;
   logic signed [VW-1:0] xlo_ff, xlo_in;
   logic signed [VW-1:0] ylo_ff, ylo_in;
   logic [MW-1:0]        mdy_ff, mdy_in;
   logic [MW-1:0]        mdist_ff, mdist_in;
   logic [MW-1:0]        mdx_ff, mdx_in;
   logic                 neg_ff, neg_in;
   logic                 dxz_ff, dxz_in;
   logic signed [VW-1:0] ya_ff, ya_in;
   logic signed [VW-1:0] res_ff, res_in;
   logic [STATUS_WIDTH-1:0] stat_ff, stat_in;

   logic                    rsp_valid_ff;
   logic signed [VW-1:0]    rsp_value_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;

   logic                 req_fire;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic signed [VW-1:0] rd_x;
   logic signed [VW-1:0] rd_y;
   logic [CW-1:0]        n_clamp;
   logic                 hit;
   logic                 scan_end;
   logic                 out_free;

   logic [MW-1:0]        dx, dy, xoff;
   logic signed [VW-1:0] xa;
   logic [PW-1:0]        prod;
   logic                 div_start;
   logic                 div_done;
   logic [PW-1:0]        quot;
   logic [CMPW-1:0]      quot_c;
   logic signed [SUMW-1:0] ya_ext, q_ext, sum;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= EXTRAP_HOLD_END;
         points_ff <= COUNT_WIDTH'(2);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXTRAP_MODE: mode_ff   <= csr_wdata[MODE_WIDTH-1:0];
            CSR_POINTS:      points_ff <= csr_wdata[COUNT_WIDTH-1:0];
         endcase
      end
   end

   // ---------------- knot tables ----------------
   assign req_fire = req_valid && !req_stall;
   assign wr_en    = req_fire && (req_command == CMD_WRITE) &&
                     (32'(req_knot_index) < 32'(MAX_POINTS));

   pli_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (AW),
      .VW    (VW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_knot_index)),
      .wr_x    (req_x_value),
      .wr_y    (req_y_value),
      .rd_addr (rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   // ---------------- divider ----------------
   assign prod = PW'(mdy_ff) * PW'(mdist_ff);

   pli_div #(
      .NW (PW),
      .DW (MW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (mdx_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // ---------------- helpers ----------------
   always_comb begin
      if (points_ff < COUNT_WIDTH'(2)) begin
         n_clamp = CW'(2);
      end else if (32'(points_ff) > 32'(MAX_POINTS)) begin
         n_clamp = CW'(MAX_POINTS);
      end else begin
         n_clamp = CW'(points_ff);
      end
   end

   // read of entry scan_ff-1 is in flight when pend_ff is set
   assign hit      = pend_ff && (rd_x >= xq_ff);
   assign scan_end = (scan_ff == n_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign xa   = anc_hi_ff ? rd_x : xlo_ff;
   assign dx   = {rd_x[VW-1], rd_x} - {xlo_ff[VW-1], xlo_ff};
   assign dy   = {rd_y[VW-1], rd_y} - {ylo_ff[VW-1], ylo_ff};
   assign xoff = {xq_ff[VW-1], xq_ff} - {xa[VW-1], xa};

   assign quot_c = CMPW'(quot);
   assign ya_ext = SUMW'(ya_ff);
   assign q_ext  = SUMW'(quot_c[SAT_LIMIT_WIDTH-1:0]);
   assign sum    = neg_ff ? (ya_ext - q_ext) : (ya_ext + q_ext);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_command == CMD_EVAL)) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (hit || scan_end) state_in = S_PICK;
         end
         S_PICK: begin
            if (idx_ff == '0) begin
               if (mode_ff == EXTRAP_HOLD_END || x0eq_ff) state_in = S_READ_END;
               else if (mode_ff == EXTRAP_LINE_END) state_in = S_READ_LO;
               else state_in = S_FINISH;
            end else if (idx_ff == n_ff) begin
               if (mode_ff == EXTRAP_HOLD_END) state_in = S_READ_END;
               else if (mode_ff == EXTRAP_LINE_END) state_in = S_READ_LO;
               else state_in = S_FINISH;
            end else begin
               state_in = S_READ_LO;
            end
         end
         S_READ_LO:  state_in = S_READ_HI;
         S_READ_HI:  state_in = S_GRAB;
         S_GRAB:     state_in = S_MUL;
         S_MUL:      state_in = dxz_ff ? S_FINISH : S_DIV;
         S_DIV: begin
            if (div_done) state_in = S_SUM;
         end
         S_SUM:      state_in = S_FINISH;
         S_READ_END: state_in = S_TAKE_END;
         S_TAKE_END: state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      rd_addr   = lo_ff;
      unique case (state_ff)
         S_IDLE:     req_stall = 1'b0;
         S_SCAN:     rd_addr   = AW'(scan_ff);
         S_READ_HI:  rd_addr   = hi_ff;
         S_MUL:      div_start = !dxz_ff;
         default:    rd_addr   = lo_ff;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      xq_in     = xq_ff;
      n_in      = n_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      x0eq_in   = x0eq_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      anc_hi_in = anc_hi_ff;
      xlo_in    = xlo_ff;
      ylo_in    = ylo_ff;
      mdy_in    = mdy_ff;
      mdist_in  = mdist_ff;
      mdx_in    = mdx_ff;
      neg_in    = neg_ff;
      dxz_in    = dxz_ff;
      ya_in     = ya_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      case (state_ff)
         S_IDLE: begin
            xq_in   = req_x_value;
            n_in    = n_clamp;
            scan_in = '0;
            pend_in = 1'b0;
         end
         S_SCAN: begin
            if (hit) begin
               idx_in  = scan_ff - CW'(1);
               x0eq_in = (rd_x == xq_ff);
            end else if (scan_end) begin
               idx_in = n_ff;
            end else begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         S_PICK: begin
            res_in  = '0;
            stat_in = STAT_NO_EXTRAP;
            if (idx_ff == '0) begin
               lo_in     = '0;
               hi_in     = AW'(1);
               anc_hi_in = 1'b0;
            end else if (idx_ff == n_ff) begin
               hi_in     = AW'(n_ff - CW'(1));
               anc_hi_in = 1'b1;
               // constant end value reads the last knot through lo
               lo_in     = (mode_ff == EXTRAP_HOLD_END) ? AW'(n_ff - CW'(1))
                                                        : AW'(n_ff - CW'(2));
            end else begin
               lo_in     = AW'(idx_ff - CW'(1));
               hi_in     = AW'(idx_ff);
               anc_hi_in = 1'b1;
            end
         end
         S_READ_HI: begin
            xlo_in = rd_x;
            ylo_in = rd_y;
         end
         S_GRAB: begin
            mdx_in   = dx[MW-1] ? -dx : dx;
            mdy_in   = dy[MW-1] ? -dy : dy;
            mdist_in = xoff[MW-1] ? -xoff : xoff;
            neg_in   = dx[MW-1] ^ dy[MW-1] ^ xoff[MW-1];
            dxz_in   = (dx == '0);
            ya_in    = anc_hi_ff ? rd_y : ylo_ff;
         end
         S_MUL: begin
            res_in  = ya_ff;
            stat_in = STAT_ZERO_WIDTH;
         end
         S_SUM: begin
            if (quot_c > CMPW'(SAT_LIMIT)) begin
               stat_in = STAT_SATURATED;
               res_in  = neg_ff ? VAL_MIN : VAL_MAX;
            end else if (sum > SUM_MAX) begin
               stat_in = STAT_SATURATED;
               res_in  = VAL_MAX;
            end else if (sum < SUM_MIN) begin
               stat_in = STAT_SATURATED;
               res_in  = VAL_MIN;
            end else begin
               stat_in = STAT_OK;
               res_in  = sum[VW-1:0];
            end
         end
         S_TAKE_END: begin
            res_in  = rd_y;
            stat_in = STAT_OK;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      xq_ff     <= xq_in;
      n_ff      <= n_in;
      scan_ff   <= scan_in;
      pend_ff   <= pend_in;
      idx_ff    <= idx_in;
      x0eq_ff   <= x0eq_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      anc_hi_ff <= anc_hi_in;
      xlo_ff    <= xlo_in;
      ylo_ff    <= ylo_in;
      mdy_ff    <= mdy_in;
      mdist_ff  <= mdist_in;
      mdx_ff    <= mdx_in;
      neg_ff    <= neg_in;
      dxz_ff    <= dxz_in;
      ya_ff     <= ya_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_value_ff  <= res_ff;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
